// ===== sv/smv_pkg.sv =====
// shared widths, defaults and the per-set record for sample_mean_variance
package smv_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 24;
    localparam int MEAN_W   = 24;
    localparam int VAR_W    = 47;
    localparam int CNT_W    = 17;

    // accumulator and back-end datapath widths
    localparam int SUM_W    = 40;
    localparam int SQ_W     = 63;
    localparam int MAG_W    = SUM_W;
    localparam int PROD_W   = 80;
    localparam int DEN_W    = 2 * CNT_W;

    // defaults for the top-level parameters
    localparam int DEF_MAX_SAMPLES = 65536;
    localparam int DEF_SAMPLE_BITS = 24;

    // depth of the queue between front and back end
    localparam int SET_FIFO_DEPTH = 2;

    // variance reported for sets with fewer than two samples (1.0)
    localparam logic [VAR_W-1:0] VAR_ONE = VAR_W'(1);
    localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

    // totals of one closed set, handed from front to back end
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sumsq;
        logic [CNT_W-1:0]        count;
        logic                    dropped;
    } smv_set_t;

endpackage

// ===== sv/smv_in_if.sv =====
// sample channel: valid/ready handshake with sample and last flag
interface smv_in_if import smv_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

// ===== sv/smv_out_if.sv =====
// result channel: valid/ready handshake with mean, variance and status
interface smv_out_if import smv_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]         variance;
    logic [CNT_W-1:0]         sample_count;
    logic                     too_few;
    logic                     overflowed;

    modport source (output valid, output mean, output variance, output sample_count,
                    output too_few, output overflowed, input ready);
    modport sink   (input valid, input mean, input variance, input sample_count,
                    input too_few, input overflowed, output ready);
endinterface

// ===== sv/smv_front.sv =====
// front end: squares each sample and accumulates count, sum and sum of squares
module smv_front import smv_pkg::*; #(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic     clk,
    input  logic     rst_n,
    smv_in_if.sink   samples,
    output smv_set_t set_data,
    output logic     set_valid,
    input  logic     set_ready
);

    localparam int SQ_BITS = 2 * SAMPLE_BITS;

    logic signed [SAMPLE_BITS-1:0] smp;
    logic signed [SQ_BITS-1:0]     sq_s;
    logic                          take;
    logic                          s1_adv;
    logic                          room;
    logic signed [SUM_W-1:0]       val_ext;
    logic [SQ_W-1:0]               sq_ext;
    logic signed [SUM_W-1:0]       sum_upd;
    logic [SQ_W-1:0]               sumsq_upd;
    logic [CNT_W-1:0]              cnt_upd;
    logic                          drop_upd;

    logic                          s1_valid_reg;
    logic                          s1_last_reg;
    logic signed [SAMPLE_BITS-1:0] s1_val_reg;
    logic [SQ_BITS-1:0]            s1_sq_reg;

    logic signed [SUM_W-1:0]       sum_reg;
    logic [SQ_W-1:0]               sumsq_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          drop_reg;

    // only the low sample bits are used
    assign smp  = $signed(samples.sample[SAMPLE_BITS-1:0]);
    assign sq_s = SQ_BITS'(smp) * SQ_BITS'(smp);

    // the closing transaction waits for room in the set queue
    assign s1_adv        = s1_valid_reg && (!s1_last_reg || set_ready);
    assign samples.ready = !s1_valid_reg || s1_adv;
    assign take          = samples.valid && samples.ready;

    assign room    = cnt_reg < CNT_W'(MAX_SAMPLES);
    assign val_ext = {{(SUM_W - SAMPLE_BITS){s1_val_reg[SAMPLE_BITS-1]}}, s1_val_reg};
    assign sq_ext  = {{(SQ_W - SQ_BITS){1'b0}}, s1_sq_reg};

    always_comb
    begin
        sum_upd   = sum_reg;
        sumsq_upd = sumsq_reg;
        cnt_upd   = cnt_reg;
        drop_upd  = drop_reg;
        if (room)
        begin
            sum_upd   = sum_reg + val_ext;
            sumsq_upd = sumsq_reg + sq_ext;
            cnt_upd   = cnt_reg + CNT_W'(1);
        end
        else
        begin
            drop_upd = 1'b1;
        end
    end

    assign set_valid        = s1_valid_reg && s1_last_reg;
    assign set_data.sum     = sum_upd;
    assign set_data.sumsq   = sumsq_upd;
    assign set_data.count   = cnt_upd;
    assign set_data.dropped = drop_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            sum_reg      <= '0;
            sumsq_reg    <= '0;
            cnt_reg      <= '0;
            drop_reg     <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s1_valid_reg <= 1'b1;
                s1_last_reg  <= samples.last;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                if (s1_last_reg)
                begin
                    sum_reg   <= '0;
                    sumsq_reg <= '0;
                    cnt_reg   <= '0;
                    drop_reg  <= 1'b0;
                end
                else
                begin
                    sum_reg   <= sum_upd;
                    sumsq_reg <= sumsq_upd;
                    cnt_reg   <= cnt_upd;
                    drop_reg  <= drop_upd;
                end
            end
        end
    end

    // sample and its square, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_val_reg <= smp;
            s1_sq_reg  <= $unsigned(sq_s);
        end
    end

endmodule

// ===== sv/smv_fifo.sv =====
// small queue of closed-set records between front and back end
module smv_fifo import smv_pkg::*; #(
    parameter int DEPTH = SET_FIFO_DEPTH
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  smv_set_t wr_data,
    output logic     rd_valid,
    input  logic     rd_ready,
    output smv_set_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    smv_set_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   fill_reg;
    logic             push;
    logic             pop;

    assign wr_ready = fill_reg != (PTR_W + 1)'(DEPTH);
    assign rd_valid = fill_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + (PTR_W + 1)'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - (PTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/smv_div.sv =====
// restoring divider, one quotient bit per cycle
module smv_div #(
    parameter int NUM_W = 80,
    parameter int DEN_W = 34
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  acc_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    rem_sub;
    logic              fits;

    // shift in the next dividend bit, subtract when it fits
    assign rem_sh  = {rem_reg, acc_reg[NUM_W-1]};
    assign fits    = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    assign busy = busy_reg;
    assign quot = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

endmodule

// ===== sv/smv_back.sv =====
// back end: per-set products, subtraction and the two divisions
module smv_back import smv_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  smv_set_t set_data,
    input  logic     set_valid,
    output logic     set_ready,
    smv_out_if.source stats
);

    localparam int STEP_W = $clog2(MAG_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                   state_reg;
    logic                     out_valid_reg;
    logic signed [MEAN_W-1:0] mean_reg;
    logic [VAR_W-1:0]         var_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     too_few_reg;
    logic                     drop_reg;

    logic                     neg_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [DEN_W-1:0]         dd_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [PROD_W-1:0]        ma_reg;
    logic [MAG_W-1:0]         ra_reg;
    logic [PROD_W-1:0]        pa_reg;
    logic [PROD_W-1:0]        mb_reg;
    logic [CNT_W-1:0]         rb_reg;
    logic [PROD_W-1:0]        pb_reg;

    logic [MAG_W-1:0]         in_mag;
    logic [DEN_W-1:0]         in_dd;
    logic                     div_start;
    logic [PROD_W-1:0]        var_num;
    logic                     busy_m;
    logic                     busy_v;
    logic [MAG_W-1:0]         quot_m;
    logic [PROD_W-1:0]        quot_v;
    logic [MAG_W-1:0]         mean_full;
    logic [VAR_W-1:0]         var_sat;

    assign set_ready = state_reg == ST_IDLE;

    assign in_mag = set_data.sum[SUM_W-1] ? MAG_W'(-set_data.sum) : MAG_W'(set_data.sum);
    assign in_dd  = DEN_W'(set_data.count) * DEN_W'(set_data.count - CNT_W'(1));

    // numerator of the variance, clamped at zero
    assign div_start = state_reg == ST_DIV_GO;
    assign var_num   = (pb_reg >= pa_reg) ? pb_reg - pa_reg : '0;

    smv_div #(
        .NUM_W (MAG_W),
        .DEN_W (CNT_W)
    ) u_div_mean (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mag_reg),
        .den   (count_reg),
        .busy  (busy_m),
        .quot  (quot_m)
    );

    smv_div #(
        .NUM_W (PROD_W),
        .DEN_W (DEN_W)
    ) u_div_var (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (var_num),
        .den   (dd_reg),
        .busy  (busy_v),
        .quot  (quot_v)
    );

    assign mean_full = neg_reg ? MAG_W'(-quot_m) : quot_m;
    assign var_sat   = (quot_v[PROD_W-1:VAR_W] != '0) ? VAR_MAX : quot_v[VAR_W-1:0];

    assign stats.valid        = out_valid_reg;
    assign stats.mean         = mean_reg;
    assign stats.variance     = var_reg;
    assign stats.sample_count = count_reg;
    assign stats.too_few      = too_few_reg;
    assign stats.overflowed   = drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mean_reg      <= '0;
            var_reg       <= '0;
            count_reg     <= '0;
            too_few_reg   <= 1'b0;
            drop_reg      <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (set_valid)
                    begin
                        count_reg <= set_data.count;
                        drop_reg  <= set_data.dropped;
                        if (set_data.count < CNT_W'(2))
                        begin
                            mean_reg      <= '0;
                            var_reg       <= VAR_ONE;
                            too_few_reg   <= 1'b1;
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_OUT;
                        end
                        else
                        begin
                            too_few_reg <= 1'b0;
                            state_reg   <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    if (step_reg == STEP_W'(1))
                    begin
                        state_reg <= ST_DIV_GO;
                    end
                end
                ST_DIV_GO:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (!busy_m && !busy_v)
                    begin
                        mean_reg      <= $signed(mean_full[MEAN_W-1:0]);
                        var_reg       <= var_sat;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (stats.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // shift-and-add products: sum^2 and count * sumsq, one bit a cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && set_valid)
        begin
            neg_reg  <= set_data.sum[SUM_W-1];
            mag_reg  <= in_mag;
            dd_reg   <= in_dd;
            step_reg <= STEP_W'(MAG_W);
            ma_reg   <= PROD_W'(in_mag);
            ra_reg   <= in_mag;
            pa_reg   <= '0;
            mb_reg   <= PROD_W'(set_data.sumsq);
            rb_reg   <= set_data.count;
            pb_reg   <= '0;
        end
        else if (state_reg == ST_MUL)
        begin
            step_reg <= step_reg - STEP_W'(1);
            pa_reg   <= ra_reg[0] ? pa_reg + ma_reg : pa_reg;
            ma_reg   <= {ma_reg[PROD_W-2:0], 1'b0};
            ra_reg   <= {1'b0, ra_reg[MAG_W-1:1]};
            pb_reg   <= rb_reg[0] ? pb_reg + mb_reg : pb_reg;
            mb_reg   <= {mb_reg[PROD_W-2:0], 1'b0};
            rb_reg   <= {1'b0, rb_reg[CNT_W-1:1]};
        end
    end

endmodule

// ===== sv/sample_mean_variance.sv =====
// top level: sample mean and unbiased variance of sets of signed samples
//
//   port      dir   payload                                           note
//   samples   sink  sample (24b signed), last                         one sample per transaction
//   stats     src   mean, variance, sample_count, too_few, overflowed one transaction per set
//
// the front end takes one sample per cycle unless a closing sample waits for the set queue;
// squares are registered and then accumulated; a set with two or more samples goes through
//   the back end as a load, 40 shift-and-add steps, a divider start, 80 divider steps,
//   registering of the result and an output transaction that waits for stats.ready
// closed sets wait in a two-entry queue; when it is full the closing sample stalls samples.ready
// a result waits in the output register until stats.ready while the front keeps accumulating
// rst_n clears the accumulators, the queue and the back-end state machine at once
module sample_mean_variance import smv_pkg::*; #(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    smv_in_if.sink    samples,
    smv_out_if.source stats
);

    // closed-set records from the accumulator
    smv_set_t front_set;
    logic     front_valid;
    logic     front_ready;

    // records offered to the back end
    smv_set_t back_set;
    logic     back_valid;
    logic     back_ready;

    // accumulate count, sum and sum of squares, close a set on last
    smv_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .set_data  (front_set),
        .set_valid (front_valid),
        .set_ready (front_ready)
    );

    // decouples the accumulator from the long per-set computation
    smv_fifo #(
        .DEPTH (SET_FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_set),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_data  (back_set)
    );

    // mean and variance of each closed set, one set at a time
    smv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .set_data  (back_set),
        .set_valid (back_valid),
        .set_ready (back_ready),
        .stats     (stats)
    );

endmodule

// ===== tb/sample_mean_variance_checker.sv =====
// checker for sample_mean_variance: predicts set statistics and compares results in order
module sample_mean_variance_checker import smv_pkg::*; #(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic clk,
    input  logic rst_n,
    smv_in_if    samples,
    smv_out_if   stats,
    output int   mismatches,
    output int   outstanding
);

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean;
        logic [VAR_W-1:0]         variance;
        logic [CNT_W-1:0]         sample_count;
        logic                     too_few;
        logic                     overflowed;
    } set_stats_t;

    // totals of the set that is still open
    logic signed [SUM_W-1:0] set_sum;
    logic [SQ_W-1:0]         set_sumsq;
    logic [CNT_W-1:0]        set_count;
    logic                    set_dropped;

    set_stats_t pending_stats[$];

    function automatic void clear_set();
        set_sum     = '0;
        set_sumsq   = '0;
        set_count   = '0;
        set_dropped = 1'b0;
    endfunction

    function automatic void take_sample(input logic signed [SAMPLE_W-1:0] raw);
        logic signed [SAMPLE_W-1:0] s;
        longint signed              sq;
        // keep only the low SAMPLE_BITS bits, sign extended
        s = raw <<< (SAMPLE_W - SAMPLE_BITS);
        s = s >>> (SAMPLE_W - SAMPLE_BITS);
        if (set_count < MAX_SAMPLES)
        begin
            sq        = longint'(s) * longint'(s);
            set_sum   = set_sum + SUM_W'(s);
            set_sumsq = set_sumsq + SQ_W'($unsigned(sq));
            set_count = set_count + CNT_W'(1);
        end
        else
        begin
            set_dropped = 1'b1;
        end
    endfunction

    // mean truncated toward zero, unbiased variance truncated and clamped
    function automatic set_stats_t close_set_stats();
        set_stats_t          r;
        logic signed [127:0] n_w;
        logic signed [127:0] s_w;
        logic signed [127:0] q_w;
        logic signed [127:0] num;
        logic [127:0]        den;
        logic [127:0]        quo;
        longint signed       avg;
        r.sample_count = set_count;
        r.overflowed   = set_dropped;
        if (set_count < 2)
        begin
            r.mean     = '0;
            r.variance = VAR_ONE;
            r.too_few  = 1'b1;
        end
        else
        begin
            n_w = 128'(set_count);
            s_w = 128'(set_sum);
            q_w = 128'(set_sumsq);
            num = n_w * q_w - s_w * s_w;
            den = 128'(set_count);
            den = den * (den - 128'(1));
            if (num < 0)
            begin
                r.variance = '0;
            end
            else
            begin
                quo        = $unsigned(num) / den;
                r.variance = (quo > VAR_MAX) ? VAR_MAX : quo[VAR_W-1:0];
            end
            avg       = longint'(set_sum) / longint'(set_count);
            r.mean    = avg[MEAN_W-1:0];
            r.too_few = 1'b0;
        end
        return r;
    endfunction

    function automatic void report_mismatch(input string what, input set_stats_t want,
                                            input set_stats_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("stats %s at %0t: expected mean=%0d var=%0d n=%0d few=%0b ovf=%0b",
                     what, $time, want.mean, want.variance, want.sample_count,
                     want.too_few, want.overflowed);
            $display("    got mean=%0d var=%0d n=%0d few=%0b ovf=%0b",
                     got.mean, got.variance, got.sample_count, got.too_few, got.overflowed);
        end
    endfunction

    // sampled at the falling edge, where both channels have settled
    always @(negedge clk)
    begin
        set_stats_t want;
        set_stats_t got;
        if (!rst_n)
        begin
            clear_set();
            pending_stats.delete();
            mismatches = 0;
        end
        else
        begin
            if (samples.valid && samples.ready)
            begin
                take_sample(samples.sample);
                if (samples.last)
                begin
                    pending_stats.insert(pending_stats.size(), close_set_stats());
                    clear_set();
                end
            end
            if (stats.valid && stats.ready)
            begin
                got.mean         = stats.mean;
                got.variance     = stats.variance;
                got.sample_count = stats.sample_count;
                got.too_few      = stats.too_few;
                got.overflowed   = stats.overflowed;
                if (pending_stats.size() == 0)
                begin
                    report_mismatch("unexpected", '0, got);
                end
                else
                begin
                    want = pending_stats.pop_front();
                    if (got !== want)
                        report_mismatch("mismatch", want, got);
                end
            end
        end
        outstanding = pending_stats.size();
    end

endmodule

// ===== tb/sample_mean_variance_tb.sv =====
// testbench top for sample_mean_variance: stimulus, receiver stalls, watchdog and verdict
module sample_mean_variance_tb;
    import smv_pkg::*;

    // receiver hold-off long enough to fill the set queue and stall samples.ready
    localparam int HOLD_CYCLES    = 600;
    // the receiver hold-off dominates any idle stretch
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int RANDOM_ITEMS   = 1330;

    localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    // how the receiver paces stats.ready over a stretch of cycles
    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_EVERY4, RX_STARVED} rx_mode_e;
    // flavor of sample values within a random set
    typedef enum int {SK_FULL, SK_SMALL, SK_EDGE, SK_NEAR} sample_kind_e;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    smv_in_if  samples();
    smv_out_if stats();

    int   mismatches;
    int   outstanding;
    int   idle_cycles = 0;
    int   burst_left  = 0;
    logic hold_req    = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    sample_mean_variance u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .stats   (stats)
    );

    sample_mean_variance_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples),
        .stats       (stats),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // offer one sample; the sender sometimes idles between bursts of random length
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic closes);
        int   gap;
        logic taken;
        if (burst_left == 0)
        begin
            gap = 0;
            case ($urandom_range(0, 9))
                6, 7, 8: gap = $urandom_range(1, 4);
                9:       gap = $urandom_range(8, 40);
                default: gap = 0;
            endcase
            if (gap > 0)
            begin
                samples.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        samples.valid  <= 1'b1;
        samples.sample <= value;
        samples.last   <= closes;
        // the transaction completes at the rising edge after a falling edge with ready high
        do
        begin
            @(negedge clk);
            taken = samples.ready;
            @(posedge clk);
        end
        while (!taken);
        burst_left--;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(
        input sample_kind_e kind, input logic signed [SAMPLE_W-1:0] centre);
        logic signed [SAMPLE_W-1:0] v;
        case (kind)
            SK_FULL:  v = SAMPLE_W'($urandom);
            SK_SMALL: v = SAMPLE_W'(int'($urandom_range(0, 200)) - 100);
            SK_EDGE:
            begin
                case ($urandom_range(0, 4))
                    0:       v = S_MIN;
                    1:       v = S_MAX;
                    2:       v = '0;
                    3:       v = '1;
                    default: v = SAMPLE_W'(1);
                endcase
            end
            default:  v = centre + SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
        endcase
        return v;
    endfunction

    // receiver: stall pattern changes every stretch, plus one long hold-off on request
    initial
    begin
        rx_mode_e mode;
        int       span;
        int       hold_left;
        logic     hold_done;
        mode        = RX_OPEN;
        span        = 0;
        hold_left   = 0;
        hold_done   = 1'b0;
        stats.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                // long hold-off: results back up into the set queue, then samples stall
                hold_left--;
                stats.ready <= 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = rx_mode_e'($urandom_range(0, 4));
                    span = $urandom_range(20, 300);
                end
                span--;
                case (mode)
                    RX_OPEN:   stats.ready <= 1'b1;
                    RX_COIN:   stats.ready <= ($urandom_range(0, 1) == 1);
                    RX_MOSTLY: stats.ready <= ($urandom_range(0, 9) != 0);
                    RX_EVERY4: stats.ready <= (span % 4 == 0);
                    default:   stats.ready <= ($urandom_range(0, 9) < 2);
                endcase
            end
        end
    end

    // watchdog: too many cycles with no transaction on either channel ends the run
    always @(negedge clk)
    begin
        if (!rst_n || (samples.valid && samples.ready) || (stats.valid && stats.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int                         set_len;
        int                         sent;
        sample_kind_e               kind;
        logic signed [SAMPLE_W-1:0] centre;
        samples.valid  = 1'b0;
        samples.sample = '0;
        samples.last   = 1'b0;
        rst_n          = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone sample: too few, mean 0 and variance 1
        send_sample(S_MAX, 1'b1);
        // two extremes: largest spread of a pair
        send_sample(S_MIN, 1'b0);
        send_sample(S_MAX, 1'b1);
        // constant sets at both extremes give zero variance
        send_sample(S_MIN, 1'b0);
        send_sample(S_MIN, 1'b1);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MAX, 1'b1);
        // negative sum: mean truncates toward zero, variance truncates to 0
        send_sample(-3, 1'b0);
        send_sample(-4, 1'b1);
        send_sample(0, 1'b0);
        send_sample(1, 1'b0);
        send_sample(2, 1'b1);
        send_sample(-1, 1'b0);
        send_sample(0, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(0, 1'b1);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(0, 1'b1);

        // random sets, mostly short; the receiver hold-off lands early in this part
        hold_req <= 1'b1;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: set_len = $urandom_range(1, 4);
                5, 6, 7:       set_len = $urandom_range(5, 16);
                8:             set_len = $urandom_range(17, 64);
                default:       set_len = 2;
            endcase
            kind   = sample_kind_e'($urandom_range(0, 3));
            centre = SAMPLE_W'($urandom);
            for (int i = 1; i <= set_len; i++)
            begin
                send_sample(($urandom_range(0, 7) == 0) ? pick_sample(SK_FULL, centre)
                                                        : pick_sample(kind, centre),
                            i == set_len);
            end
            sent += set_len;
        end
        samples.valid <= 1'b0;

        // every set is closed, so wait for the last result and let the block settle
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sample_mean_variance.f =====
sv/smv_pkg.sv
sv/smv_in_if.sv
sv/smv_out_if.sv
sv/smv_front.sv
sv/smv_fifo.sv
sv/smv_div.sv
sv/smv_back.sv
sv/sample_mean_variance.sv
tb/sample_mean_variance_checker.sv
tb/sample_mean_variance_tb.sv
